@@ hw/rtl/serial_command_parser_assert.svh @@
// Assertion macros shared by the serial command parser RTL.
`ifndef SERIAL_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scp assertion failed");

// Next-cycle implication, disabled during reset.
`define SCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scp assertion failed");

`endif

@@ hw/rtl/scp_pkg.sv @@
// Types and constants for the serial command parser.
package scp_pkg;

	localparam int VALUE_COUNT_DEF = 2;

	localparam logic [7:0]  KEY_ESC     = 8'd27;
	localparam logic [7:0]  KEY_SPACE   = 8'h20;
	localparam logic [7:0]  KEY_ZERO    = 8'h30;
	localparam logic [7:0]  KEY_NINE    = 8'h39;
	localparam logic [7:0]  KEY_COMMA   = 8'h2c;
	localparam logic [7:0]  KEY_COLON   = 8'h3a;
	localparam logic [7:0]  KEY_S_LO    = 8'h73;
	localparam logic [7:0]  KEY_S_UP    = 8'h53;
	localparam logic [7:0]  KEY_R_LO    = 8'h72;
	localparam logic [7:0]  KEY_R_UP    = 8'h52;
	localparam logic [7:0]  KEY_V_LO    = 8'h76;
	localparam logic [7:0]  KEY_V_UP    = 8'h56;
	localparam logic [15:0] CODE_BOOT   = 16'd5511;
	localparam logic [15:0] CODE_REBOOT = 16'd1033;

	typedef enum logic [1:0] {
		PH_COMMAND,
		PH_TARGET,
		PH_NEXT,
		PH_VALUE
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_STATUS,
		CMD_RESET,
		CMD_VALVE
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_STATUS,
		ACT_BOOT,
		ACT_REBOOT,
		ACT_BAD_CODE,
		ACT_VALVE,
		ACT_BAD_TARGET,
		ACT_BAD_CMD_CHAR,
		ACT_BAD_TARGET_CHAR
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [3:0]  valve_number;
		logic [15:0] first_value;
		logic [15:0] second_value;
		logic [7:0]  offending_char;
	} result_t;

endpackage

@@ hw/rtl/scp_parser.sv @@
// Parser state and per-byte decode for the serial command parser.
`include "serial_command_parser_assert.svh"

module scp_parser
	import scp_pkg::*;
#(
	parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	output logic       has_res,
	output result_t    res
);

	localparam int SLOT_W = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VALUE_COUNT - 1);

	phase_t            phase_q, phase_d;
	cmd_t              cmd_q, cmd_d;
	logic [3:0]        tgt_q, tgt_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [15:0]       store_q [VALUE_COUNT];
	logic [15:0]       store_d [VALUE_COUNT];
	logic              clr;

	logic        is_digit, is_esc, above_sp, is_sep, is_s, is_r, is_v, last_slot;
	logic [3:0]  dig;
	logic [15:0] cur, acc, second_val;
	action_t     done_act;

	assign is_digit  = (byte_in >= KEY_ZERO) && (byte_in <= KEY_NINE);
	assign is_esc    = (byte_in == KEY_ESC);
	assign above_sp  = (byte_in > KEY_SPACE);
	assign is_sep    = (byte_in == KEY_COMMA) || (byte_in == KEY_COLON);
	assign is_s      = (byte_in == KEY_S_LO) || (byte_in == KEY_S_UP);
	assign is_r      = (byte_in == KEY_R_LO) || (byte_in == KEY_R_UP);
	assign is_v      = (byte_in == KEY_V_LO) || (byte_in == KEY_V_UP);
	assign dig       = 4'(byte_in - KEY_ZERO);
	assign last_slot = (slot_q == LAST_SLOT);
	assign cur       = store_q[slot_q];
	assign acc       = (cur << 3) + (cur << 1) + {12'b0, dig};

	generate
		if (VALUE_COUNT > 1) begin : g_second
			assign second_val = store_q[1];
		end else begin : g_no_second
			assign second_val = 16'b0;
		end
	endgenerate

	// next state
	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		tgt_d   = tgt_q;
		slot_d  = slot_q;
		store_d = store_q;
		clr     = 1'b0;
		unique case (phase_q)
			PH_COMMAND: begin
				priority if (is_s) begin
					clr = 1'b1;
				end else if (is_r) begin
					cmd_d   = CMD_RESET;
					phase_d = PH_NEXT;
				end else if (is_v) begin
					cmd_d   = CMD_VALVE;
					phase_d = PH_TARGET;
				end else begin
					clr = above_sp;
				end
			end
			PH_TARGET: begin
				priority if (is_esc) begin
					clr = 1'b1;
				end else if (is_digit) begin
					tgt_d   = dig;
					phase_d = PH_NEXT;
				end else begin
					clr = above_sp;
				end
			end
			PH_NEXT: begin
				if (is_esc) begin
					clr = 1'b1;
				end else if (is_digit) begin
					store_d[slot_q] = {12'b0, dig};
					phase_d         = PH_VALUE;
				end
			end
			PH_VALUE: begin
				priority if (is_esc) begin
					clr = 1'b1;
				end else if (is_digit) begin
					store_d[slot_q] = acc;
				end else if (is_sep && !last_slot) begin
					slot_d  = slot_q + 1'b1;
					phase_d = PH_NEXT;
				end else begin
					clr = 1'b1;
				end
			end
			default: clr = 1'b1;
		endcase
	end

	always_comb begin
		priority if (cmd_q == CMD_RESET) begin
			priority if (store_q[0] == CODE_BOOT) done_act = ACT_BOOT;
			else if (store_q[0] == CODE_REBOOT) done_act = ACT_REBOOT;
			else done_act = ACT_BAD_CODE;
		end else begin
			done_act = (tgt_q <= 4'd1) ? ACT_VALVE : ACT_BAD_TARGET;
		end
	end

	// outputs
	always_comb begin
		has_res            = 1'b0;
		res.action         = done_act;
		res.valve_number   = tgt_q;
		res.first_value    = store_q[0];
		res.second_value   = second_val;
		res.offending_char = 8'b0;
		unique case (phase_q)
			PH_COMMAND: begin
				priority if (is_s) begin
					has_res    = 1'b1;
					res.action = ACT_STATUS;
				end else if (!is_r && !is_v && above_sp) begin
					has_res            = 1'b1;
					res.action         = ACT_BAD_CMD_CHAR;
					res.offending_char = byte_in;
				end else begin
					has_res = 1'b0;
				end
			end
			PH_TARGET: begin
				if (!is_esc && !is_digit && above_sp) begin
					has_res            = 1'b1;
					res.action         = ACT_BAD_TARGET_CHAR;
					res.offending_char = byte_in;
				end
			end
			PH_NEXT: has_res = 1'b0;
			PH_VALUE: has_res = !is_esc && !is_digit && !(is_sep && !last_slot);
			default: has_res = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COMMAND;
			cmd_q   <= CMD_NONE;
			tgt_q   <= 4'b0;
			slot_q  <= '0;
			for (int i = 0; i < VALUE_COUNT; i++) store_q[i] <= 16'b0;
		end else if (step) begin
			if (clr) begin
				phase_q <= PH_COMMAND;
				cmd_q   <= CMD_NONE;
				tgt_q   <= 4'b0;
				slot_q  <= '0;
				for (int i = 0; i < VALUE_COUNT; i++) store_q[i] <= 16'b0;
			end else begin
				phase_q <= phase_d;
				cmd_q   <= cmd_d;
				tgt_q   <= tgt_d;
				slot_q  <= slot_d;
				store_q <= store_d;
			end
		end
	end

	`SCP_ASSERT_IMPL(a_slot_range, 1'b1, slot_q <= LAST_SLOT)
	`SCP_ASSERT_IMPL(a_idle_clean, phase_q == PH_COMMAND, (cmd_q == CMD_NONE) && (slot_q == '0))
	`SCP_ASSERT_IMPL(a_target_valve, phase_q == PH_TARGET, cmd_q == CMD_VALVE)

endmodule

@@ hw/rtl/scp_out_reg.sv @@
// Result register for the serial command parser output channel.
module scp_out_reg
	import scp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_stall,
	output logic    out_vld,
	output result_t res_q
);

	logic vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_vld = vld_q;

endmodule

@@ hw/rtl/serial_command_parser.sv @@
// Serial command parser top level.
// Takes one received byte per transaction on the input channel (in_valid,
// in_stall, rx_byte) and decodes the s, r<n> and v<d><n> commands.
// A completed command, or a bad command or target character, yields one
// result transaction on the output channel (out_valid, out_stall, action,
// valve_number, first_value, second_value, offending_char).
// Datapath: an accepted byte waits in the input register and is decoded
// combinationally; its result, if any, goes into the result register
// that drives the output ports. Throughput: one byte per cycle while the
// receiver does not stall, set by the input and result registers.
// When the receiver stalls, the result register holds; the byte in the
// input register waits and in_stall rises until the result is taken.
// A byte that gives no result still needs the result register free.
// Reset clears the parser to the command phase, drops any held byte and
// any pending result.
`include "serial_command_parser_assert.svh"

module serial_command_parser
	import scp_pkg::*;
#(
	parameter int VALUE_COUNT = VALUE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [3:0]  valve_number,
	output logic [15:0] first_value,
	output logic [15:0] second_value,
	output logic [7:0]  offending_char
);

	logic       s1_vld_q;
	logic [7:0] rx_byte_s1;
	logic       step, accept, has_res, out_vld;
	result_t    res, res_q;

	assign step     = s1_vld_q && (!out_vld || !out_stall);
	assign in_stall = s1_vld_q && !step;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (step) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	scp_parser #(
		.VALUE_COUNT(VALUE_COUNT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (rx_byte_s1),
		.has_res (has_res),
		.res     (res)
	);

	scp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && has_res),
		.res_in    (res),
		.out_stall (out_stall),
		.out_vld   (out_vld),
		.res_q     (res_q)
	);

	assign out_valid      = out_vld;
	assign action         = res_q.action;
	assign valve_number   = res_q.valve_number;
	assign first_value    = res_q.first_value;
	assign second_value   = res_q.second_value;
	assign offending_char = res_q.offending_char;

	`SCP_ASSERT_NEXT(a_result_lands, step && has_res, out_vld)
	`SCP_ASSERT_NEXT(a_byte_held, s1_vld_q && !step, s1_vld_q && $stable(rx_byte_s1))
	`SCP_ASSERT_NEXT(a_result_held, out_vld && out_stall, out_vld && $stable(res_q))

endmodule
